FILE: src/atpp_pkg.sv
// shared types and constants of the adaptive threshold peak picker
package atpp_pkg;

  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned STATE_W  = 24;
  localparam int unsigned COEFF_W  = 16;
  localparam int unsigned COUNT_W  = 16;
  localparam int unsigned PEAK_W   = 23;
  localparam int unsigned CFG_IDX_W = 3;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_SMOOTH_ATTACK  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SMOOTH_RELEASE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESH_ATTACK  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESH_RELEASE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_SPACING    = 3'd4;

  // register reset values
  localparam logic [COEFF_W-1:0] SMOOTH_ATTACK_RST  = 16'd11881;
  localparam logic [COEFF_W-1:0] SMOOTH_RELEASE_RST = 16'd2148;
  localparam logic [COEFF_W-1:0] THRESH_ATTACK_RST  = 16'd2148;
  localparam logic [COEFF_W-1:0] THRESH_RELEASE_RST = 16'd652;
  localparam logic [COUNT_W-1:0] MIN_SPACING_RST    = 16'd50;

  // 0.05 in q1.23
  localparam logic signed [STATE_W-1:0] PEAK_FLOOR = 24'sd419430;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FIRST,
    ST_SECOND,
    ST_THRESH,
    ST_PEAK
  } seq_state_e;

  typedef enum logic [1:0] {
    OP_FIRST,
    OP_SECOND,
    OP_THRESH
  } op_sel_e;

  typedef struct packed {
    logic    take;      // input transfer, latch the sample
    op_sel_e sel;       // smoother operands routed to the shared unit
    logic    first_en;
    logic    second_en;
    logic    thresh_en;
    logic    peak_en;   // peak tracking update and result load
  } seq_ctrl_t;

endpackage

FILE: src/atpp_stream_if.sv
// valid/ready channels for samples and results
interface atpp_sample_if import atpp_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface atpp_result_if import atpp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              picked;
  logic [PEAK_W-1:0] peak_value;

  modport source (output valid, output picked, output peak_value, input ready);
  modport sink   (input valid, input picked, input peak_value, output ready);
endinterface

FILE: src/atpp_one_pole.sv
// shared one-pole smoother step: s + round(c * (t - s) / 2^16), saturated
module atpp_one_pole import atpp_pkg::*; (
  input  logic signed [STATE_W-1:0] state_i,
  input  logic signed [STATE_W-1:0] target_i,
  input  logic        [COEFF_W-1:0] coeff_i,
  output logic signed [STATE_W-1:0] result_o
);

  logic signed [STATE_W:0]           diff;
  logic signed [COEFF_W+STATE_W:0]   prod;
  logic signed [COEFF_W+STATE_W+1:0] rnd;
  logic signed [STATE_W+1:0]         step;
  logic signed [STATE_W+1:0]         sum;

  assign diff = {target_i[STATE_W-1], target_i} - {state_i[STATE_W-1], state_i};
  assign prod = $signed({1'b0, coeff_i}) * diff;
  assign rnd  = {prod[COEFF_W+STATE_W], prod} + (COEFF_W+STATE_W+2)'(32768);
  // floor division by 2^16
  assign step = rnd[COEFF_W+STATE_W+1:COEFF_W];
  assign sum  = {{2{state_i[STATE_W-1]}}, state_i} + step;

  always_comb begin
    if (sum > (STATE_W+2)'(8388607)) begin
      result_o = 24'sh7FFFFF;
    end else if (sum < -(STATE_W+2)'(8388608)) begin
      result_o = 24'sh800000;
    end else begin
      result_o = sum[STATE_W-1:0];
    end
  end

endmodule

FILE: src/atpp_seq.sv
// sequencer that walks one sample through the three smoothers and the peak step
module atpp_seq import atpp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      out_free_i,
  output logic      in_ready_o,
  output seq_ctrl_t ctrl_o
);

  seq_state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (in_valid_i) state_d = ST_FIRST;
      ST_FIRST:  state_d = ST_SECOND;
      ST_SECOND: state_d = ST_THRESH;
      ST_THRESH: state_d = ST_PEAK;
      ST_PEAK:   if (out_free_i) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o       = 1'b0;
    ctrl_o           = '0;
    ctrl_o.sel       = OP_FIRST;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o  = 1'b1;
        ctrl_o.take = in_valid_i;
      end
      ST_FIRST: begin
        ctrl_o.sel      = OP_FIRST;
        ctrl_o.first_en = 1'b1;
      end
      ST_SECOND: begin
        ctrl_o.sel       = OP_SECOND;
        ctrl_o.second_en = 1'b1;
      end
      ST_THRESH: begin
        ctrl_o.sel       = OP_THRESH;
        ctrl_o.thresh_en = 1'b1;
      end
      ST_PEAK: begin
        // hold here until the output slot can take the result
        ctrl_o.peak_en = out_free_i;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: src/adaptive_threshold_peak_picker_unit.sv
// top level of the adaptive threshold peak picker
//
// usage:
// - sample_i carries one signed q1.15 envelope sample per transfer, result_o
//   carries one result per sample: a picked flag and the unsigned q0.23 peak value
//   (zero when nothing is picked)
// - cfg_we_i/cfg_idx_i/cfg_wdata_i write the four q0.16 smoother
//   coefficients and the minimum peak spacing; write only while idle
// - one multiplier is shared by the three smoothers, one smoother per cycle,
//   so a sample passes through the three smoother steps and the peak
//   tracking step in turn; the result is in the output register in the same
//   cycle in which sample_i is ready again
// - a new sample is taken only after the previous one has left the peak
//   step, since transfers are taken only in the idle state
// - a stalled receiver holds the result in the output register; a new sample
//   is still taken and processed, and only its peak step waits for the slot
// - reset clears all smoother and peak state, loads the register defaults and
//   loads the spacing counter with the default minimum spacing
module adaptive_threshold_peak_picker_unit import atpp_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  atpp_sample_if.sink          sample_i,
  atpp_result_if.source        result_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [COEFF_W-1:0]   cfg_wdata_i
);

  // configuration registers
  logic [COEFF_W-1:0] smooth_att_q, smooth_rel_q, thresh_att_q, thresh_rel_q;
  logic [COUNT_W-1:0] min_spacing_q;

  // filter and peak state
  logic signed [SAMPLE_W-1:0] sample_q;
  logic signed [STATE_W-1:0]  first_q, second_q, thresh_q, held_q;
  logic [COUNT_W-1:0]         spacing_q;

  // output register
  logic              out_valid_q;
  logic              out_picked_q;
  logic [PEAK_W-1:0] out_peak_q;

  seq_ctrl_t ctrl;
  logic      out_free;

  logic signed [STATE_W-1:0] x_in;
  logic signed [STATE_W-1:0] op_state, op_target, op_result;
  logic        [COEFF_W-1:0] op_coeff;

  // peak step outcome
  logic pick;

  assign out_free = !out_valid_q || result_o.ready;

  atpp_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (sample_i.valid),
    .out_free_i (out_free),
    .in_ready_o (sample_i.ready),
    .ctrl_o     (ctrl)
  );

  // q1.15 widened to q1.23
  assign x_in = {sample_q, 8'h00};

  // operand routing for the shared smoother unit
  always_comb begin
    unique case (ctrl.sel)
      OP_FIRST: begin
        op_state  = first_q;
        op_target = x_in;
        op_coeff  = (first_q > x_in) ? smooth_rel_q : smooth_att_q;
      end
      OP_SECOND: begin
        op_state  = second_q;
        op_target = first_q;
        op_coeff  = smooth_att_q;
      end
      OP_THRESH: begin
        op_state  = thresh_q;
        op_target = second_q;
        op_coeff  = (thresh_q > second_q) ? thresh_rel_q : thresh_att_q;
      end
      default: begin
        op_state  = first_q;
        op_target = x_in;
        op_coeff  = smooth_att_q;
      end
    endcase
  end

  atpp_one_pole u_one_pole (
    .state_i  (op_state),
    .target_i (op_target),
    .coeff_i  (op_coeff),
    .result_o (op_result)
  );

  // pick when the refractory count has run out, the signal has left the
  // tracking region and the held peak clears the floor
  always_comb begin
    pick = 1'b0;
    if (spacing_q == '0 && !(second_q >= thresh_q && second_q >= held_q) &&
        held_q > PEAK_FLOOR) begin
      pick = 1'b1;
    end
  end

  // configuration writes, unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      smooth_att_q  <= SMOOTH_ATTACK_RST;
      smooth_rel_q  <= SMOOTH_RELEASE_RST;
      thresh_att_q  <= THRESH_ATTACK_RST;
      thresh_rel_q  <= THRESH_RELEASE_RST;
      min_spacing_q <= MIN_SPACING_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SMOOTH_ATTACK:  smooth_att_q  <= cfg_wdata_i;
        CFG_SMOOTH_RELEASE: smooth_rel_q  <= cfg_wdata_i;
        CFG_THRESH_ATTACK:  thresh_att_q  <= cfg_wdata_i;
        CFG_THRESH_RELEASE: thresh_rel_q  <= cfg_wdata_i;
        CFG_MIN_SPACING:    min_spacing_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.take) begin
      sample_q <= sample_i.sample;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q   <= '0;
      second_q  <= '0;
      thresh_q  <= '0;
      held_q    <= '0;
      spacing_q <= MIN_SPACING_RST;
    end else begin
      if (ctrl.first_en)  first_q  <= op_result;
      if (ctrl.second_en) second_q <= op_result;
      if (ctrl.thresh_en) thresh_q <= op_result;
      if (ctrl.peak_en) begin
        priority if (spacing_q != '0) begin
          spacing_q <= spacing_q - 1'b1;
        end else if (second_q >= thresh_q && second_q >= held_q) begin
          held_q <= second_q;
        end else begin
          // signal fell away, emit and rearm only above the floor
          if (pick) begin
            held_q    <= '0;
            spacing_q <= min_spacing_q;
          end
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl.peak_en) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.peak_en) begin
      out_picked_q <= pick;
      out_peak_q   <= pick ? held_q[PEAK_W-1:0] : '0;
    end
  end

  assign result_o.valid      = out_valid_q;
  assign result_o.picked     = out_picked_q;
  assign result_o.peak_value = out_peak_q;

endmodule

FILE: src/atpp_checker.sv
// port-level checks of the peak picker, bound to the top level
module atpp_checker import atpp_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_i,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input logic              out_picked_i,
  input logic [PEAK_W-1:0] out_peak_i
);

  // a sample occupies the datapath, so no transfer in the following cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) |=> !in_ready_i)
    else $error("sample transfer taken while datapath busy");

  // an unpicked result carries a zero peak
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_picked_i) |-> (out_peak_i == '0))
    else $error("nonzero peak without pick");

  // a picked peak always clears the floor
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && out_picked_i) |-> ({1'b0, out_peak_i} > PEAK_FLOOR))
    else $error("picked peak below floor");

  // a stalled result stays put
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=>
      (out_valid_i && $stable(out_picked_i) && $stable(out_peak_i)))
    else $error("stalled result changed");

endmodule

bind adaptive_threshold_peak_picker_unit atpp_checker u_atpp_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (sample_i.valid),
  .in_ready_i   (sample_i.ready),
  .out_valid_i  (result_o.valid),
  .out_ready_i  (result_o.ready),
  .out_picked_i (result_o.picked),
  .out_peak_i   (result_o.peak_value)
);

FILE: dv/tb_adaptive_threshold_peak_picker_unit.sv
// self-checking testbench of the adaptive threshold peak picker unit
module tb_adaptive_threshold_peak_picker_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import atpp_pkg::*;

  localparam int CLK_PERIOD     = 4;
  localparam int RESET_CYCLES   = 7;
  localparam int SETTLE_CYCLES  = 8;        // margin beyond the time one sample spends in the block
  localparam int DRAIN_CYCLES   = 20;
  localparam int TIMEOUT_CYCLES = 400_000;
  localparam int HOLD_OFF_AFTER = 600;      // transfers taken before the long stall
  localparam int HOLD_OFF_LEN   = 400;

  // idle / stall percentages of the two random traffic modes
  localparam int SEND_IDLE_A  = 14;
  localparam int RECV_STALL_A = 76;
  localparam int SEND_IDLE_B  = 76;
  localparam int RECV_STALL_B = 14;

  localparam longint STATE_MAX = (64'sd1 <<< (STATE_W - 1)) - 1;
  localparam longint STATE_MIN = -(64'sd1 <<< (STATE_W - 1));
  localparam int     SAMPLE_MAX = (1 << (SAMPLE_W - 1)) - 1;
  localparam int     SAMPLE_MIN = -(1 << (SAMPLE_W - 1));

  typedef struct packed {
    logic              picked;
    logic [PEAK_W-1:0] peak_value;
  } pick_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [COEFF_W-1:0]   cfg_wdata;
  logic                 hold_off = 1'b0;

  atpp_sample_if sample_bus ();
  atpp_result_if result_bus ();

  adaptive_threshold_peak_picker_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .sample_i    (sample_bus),
    .result_o    (result_bus),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  // samples waiting for the driver, predicted picks waiting for the monitor
  logic signed [SAMPLE_W-1:0] sample_queue[$];
  pick_t                      pending_picks[$];

  int send_idle_pct  = SEND_IDLE_A;
  int recv_stall_pct = RECV_STALL_A;
  int taken_count    = 0;
  int error_count    = 0;

  // predictor copy of the registers
  logic [COEFF_W-1:0] attack_c     = SMOOTH_ATTACK_RST;
  logic [COEFF_W-1:0] release_c    = SMOOTH_RELEASE_RST;
  logic [COEFF_W-1:0] th_attack_c  = THRESH_ATTACK_RST;
  logic [COEFF_W-1:0] th_release_c = THRESH_RELEASE_RST;
  logic [COUNT_W-1:0] spacing_reload = MIN_SPACING_RST;

  // predictor copy of the datapath state, q1.23
  logic signed [STATE_W-1:0] env_fast   = '0;
  logic signed [STATE_W-1:0] env_slow   = '0;
  logic signed [STATE_W-1:0] thresh     = '0;
  logic signed [STATE_W-1:0] peak_hold  = '0;
  logic [COUNT_W-1:0]        refractory = MIN_SPACING_RST;

  // full-scale extremes, bit patterns, steps and small values around zero
  int directed_samples [0:24] = '{
    32767, -32768, 0, -1, 1, 21845, -21846, 32767, 32767, 32767,
    32767, 32767, 32767, -32768, -32768, -32768, 0, 0, 16384, -16384,
    256, -256, 32767, 1, -32768
  };

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // one-pole step: cur + round(coeff * (goal - cur) / 2^16), half rounds up,
  // saturated to the signed 24-bit range
  function automatic logic signed [STATE_W-1:0] glide(
    input logic signed [STATE_W-1:0] cur,
    input logic signed [STATE_W-1:0] goal,
    input logic [COEFF_W-1:0]        coeff
  );
    longint prod;
    longint sum;
    prod = longint'(coeff) * (longint'(goal) - longint'(cur)) + 64'sd32768;
    sum  = longint'(cur) + (prod >>> 16);   // arithmetic shift is a floor
    if (sum > STATE_MAX) sum = STATE_MAX;
    if (sum < STATE_MIN) sum = STATE_MIN;
    return sum[STATE_W-1:0];
  endfunction

  // advance the predictor by one sample and return the pick it causes
  function automatic pick_t next_pick(input logic signed [SAMPLE_W-1:0] smp);
    logic signed [STATE_W-1:0] x;
    pick_t                     res;
    x   = {smp, 8'h00};
    res = '0;
    // asymmetric smoother: release only while falling below the envelope
    env_fast = glide(env_fast, x, (env_fast > x) ? release_c : attack_c);
    env_slow = glide(env_slow, env_fast, attack_c);
    thresh   = glide(thresh, env_slow, (thresh > env_slow) ? th_release_c : th_attack_c);
    if (refractory != '0) begin
      // refractory period, nothing is tracked
      refractory = refractory - 1'b1;
    end else if (env_slow >= thresh && env_slow >= peak_hold) begin
      peak_hold = env_slow;
    end else if (peak_hold > PEAK_FLOOR) begin
      // signal fell away from a peak above the floor
      res.picked     = 1'b1;
      res.peak_value = peak_hold[PEAK_W-1:0];
      peak_hold      = '0;
      refractory     = spacing_reload;
    end
    return res;
  endfunction

  // driver: offers the next queued sample, predicts on every transfer
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_bus.valid  <= 1'b0;
      sample_bus.sample <= '0;
    end else begin
      if (sample_bus.valid && sample_bus.ready) begin
        pending_picks.push_back(next_pick(sample_bus.sample));
        taken_count++;
      end
      // a new sample may be put up only when the bus is free or just moved
      if (!sample_bus.valid || sample_bus.ready) begin
        if (sample_queue.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          sample_bus.valid  <= 1'b1;
          sample_bus.sample <= sample_queue.pop_front();
        end else begin
          sample_bus.valid <= 1'b0;
        end
      end
    end
  end

  // monitor: random backpressure, compares every result transfer
  always @(posedge clk_i or negedge rst_ni) begin : monitor
    pick_t want;
    if (!rst_ni) begin
      result_bus.ready <= 1'b0;
    end else begin
      if (result_bus.valid && result_bus.ready) begin
        if (pending_picks.size() == 0) begin
          $display("%t: unexpected result, expected none, actual picked %0d peak %0d",
                   $time, result_bus.picked, result_bus.peak_value);
          error_count++;
        end else begin
          want = pending_picks.pop_front();
          if (result_bus.picked !== want.picked) begin
            $display("%t: picked mismatch, expected %0d, actual %0d",
                     $time, want.picked, result_bus.picked);
            error_count++;
          end
          if (result_bus.peak_value !== want.peak_value) begin
            $display("%t: peak_value mismatch, expected %0d, actual %0d",
                     $time, want.peak_value, result_bus.peak_value);
            error_count++;
          end
        end
      end
      result_bus.ready <= !hold_off && ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // long receiver stall while samples keep coming, fills the block up
  initial begin
    wait (taken_count >= HOLD_OFF_AFTER);
    @(posedge clk_i);
    hold_off <= 1'b1;
    repeat (HOLD_OFF_LEN) @(posedge clk_i);
    hold_off <= 1'b0;
  end

  // watchdog
  initial begin
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("Mismatches found");
    $finish;
  end

  // clamp to the q1.15 range and queue
  task automatic push_sample(input int v);
    if (v > SAMPLE_MAX) v = SAMPLE_MAX;
    if (v < SAMPLE_MIN) v = SAMPLE_MIN;
    sample_queue.push_back(v[SAMPLE_W-1:0]);
  endtask

  // mostly envelope-like pulses (rise, hold, fall, quiet) with random content,
  // some of them cut short, plus stretches of raw noise
  task automatic add_pulse_train(input int n_items);
    int start;
    int amp;
    int rise_len;
    int hold_len;
    int fall_len;
    int quiet_len;
    int base;
    int jit;
    start = sample_queue.size();
    while (sample_queue.size() - start < n_items) begin
      if ($urandom_range(0, 99) < 20) begin
        repeat ($urandom_range(1, 20)) push_sample(int'($urandom_range(0, 65535)) - 32768);
      end else begin
        amp       = $urandom_range(1500, 32767);
        rise_len  = $urandom_range(1, 10);
        hold_len  = $urandom_range(0, 15);
        fall_len  = $urandom_range(1, 15);
        quiet_len = $urandom_range(5, 60);
        base      = int'($urandom_range(0, 1200)) - 600;
        jit       = $urandom_range(0, 1000);
        for (int i = 1; i <= rise_len; i++)
          push_sample(amp * i / rise_len + int'($urandom_range(0, jit)) - jit / 2);
        for (int i = 0; i < hold_len; i++)
          push_sample(amp + int'($urandom_range(0, jit)) - jit / 2);
        if ($urandom_range(0, 99) < 15) begin
          // broken pulse: drops straight to the bottom
          repeat ($urandom_range(1, 4)) push_sample(SAMPLE_MIN);
        end else begin
          for (int i = fall_len - 1; i >= 0; i--)
            push_sample(amp * i / fall_len + int'($urandom_range(0, jit)) - jit / 2);
        end
        for (int i = 0; i < quiet_len; i++)
          push_sample(base + int'($urandom_range(0, 400)) - 200);
      end
    end
  endtask

  // wait until every sample went in and every result came out
  task automatic settle();
    while (sample_queue.size() != 0 || sample_bus.valid || pending_picks.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // register write, held until the next write or end_writes
  task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COEFF_W-1:0] val);
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_SMOOTH_ATTACK:  attack_c       = val;
      CFG_SMOOTH_RELEASE: release_c      = val;
      CFG_THRESH_ATTACK:  th_attack_c    = val;
      CFG_THRESH_RELEASE: th_release_c   = val;
      CFG_MIN_SPACING:    spacing_reload = val;   // running count left alone
      default: ;                                  // unused index, ignored
    endcase
  endtask

  task automatic end_writes();
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic run_phase(
    input logic [COEFF_W-1:0] sa,
    input logic [COEFF_W-1:0] sr,
    input logic [COEFF_W-1:0] ta,
    input logic [COEFF_W-1:0] tr,
    input logic [COUNT_W-1:0] ms,
    input int                 n_items,
    input int                 send_pct,
    input int                 recv_pct
  );
    settle();
    set_reg(CFG_SMOOTH_ATTACK, sa);
    set_reg(CFG_SMOOTH_RELEASE, sr);
    set_reg(CFG_THRESH_ATTACK, ta);
    set_reg(CFG_THRESH_RELEASE, tr);
    set_reg(CFG_MIN_SPACING, ms);
    end_writes();
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    add_pulse_train(n_items);
  endtask

  initial begin
    // every input known from time zero
    sample_bus.valid  = 1'b0;
    sample_bus.sample = '0;
    result_bus.ready  = 1'b0;
    cfg_we            = 1'b0;
    cfg_idx           = '0;
    cfg_wdata         = '0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // writes to indexes past the register list must leave the defaults alone
    for (int i = int'(CFG_MIN_SPACING) + 1; i < (1 << CFG_IDX_W); i++)
      set_reg(i[CFG_IDX_W-1:0], COEFF_W'($urandom_range(0, 65535)));
    end_writes();

    // directed samples at the reset defaults, the first refractory count runs
    foreach (directed_samples[i]) push_sample(directed_samples[i]);

    // sender idles a little, receiver stalls a lot
    run_phase(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0, 200,
              SEND_IDLE_A, RECV_STALL_A);
    // all coefficients zero: the smoothers never move
    run_phase(16'd0, 16'd0, 16'd0, 16'd0, 16'd1, 100, SEND_IDLE_A, RECV_STALL_A);

    // the other way round, long receiver stall falls in here
    run_phase(SMOOTH_ATTACK_RST, SMOOTH_RELEASE_RST, THRESH_ATTACK_RST,
              THRESH_RELEASE_RST, MIN_SPACING_RST, 400, SEND_IDLE_B, RECV_STALL_B);
    run_phase(COEFF_W'($urandom_range(8000, 40000)), COEFF_W'($urandom_range(1000, 8000)),
              COEFF_W'($urandom_range(1000, 6000)), COEFF_W'($urandom_range(200, 2000)),
              COUNT_W'($urandom_range(0, 40)), 400, SEND_IDLE_B, RECV_STALL_B);
    // longest spacing: at most one pick, then the count runs through
    run_phase(COEFF_W'($urandom_range(8000, 40000)), COEFF_W'($urandom_range(1000, 8000)),
              COEFF_W'($urandom_range(1000, 6000)), COEFF_W'($urandom_range(200, 2000)),
              16'hFFFF, 100, SEND_IDLE_B, RECV_STALL_B);

    // no idling at all; the spacing write lands while the long count runs
    run_phase(COEFF_W'($urandom_range(0, 65535)), COEFF_W'($urandom_range(0, 65535)),
              COEFF_W'($urandom_range(0, 65535)), COEFF_W'($urandom_range(0, 65535)),
              COUNT_W'($urandom_range(0, 20)), 300, 0, 0);
    run_phase(COEFF_W'($urandom_range(6000, 30000)), COEFF_W'($urandom_range(1000, 6000)),
              COEFF_W'($urandom_range(1000, 5000)), COEFF_W'($urandom_range(200, 1500)),
              COUNT_W'($urandom_range(5, 30)), 300, 0, 0);

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

FILE: files.f
src/atpp_pkg.sv
src/atpp_stream_if.sv
src/atpp_one_pole.sv
src/atpp_seq.sv
src/adaptive_threshold_peak_picker_unit.sv
src/atpp_checker.sv
dv/tb_adaptive_threshold_peak_picker_unit.sv
